FILE: hw/rtl/sva_pkg.sv
package sva_pkg;

  localparam int VOL_W   = 16;
  localparam int DIST_W  = 32;
  localparam int PRES_W  = 32;
  localparam int RANGE_W = 16;
  localparam int QUO_W   = 16;
  localparam int NUM_W   = 48;
  localparam int CFG_W   = 32;
  localparam int CIDX_W  = 3;

  localparam logic [VOL_W-1:0]  VOL_FULL  = 16'h8000;
  localparam logic [DIST_W-1:0] DIST_MIN  = 32'd2;

  localparam logic [CIDX_W-1:0] CFG_SILENCE  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FAR      = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_MEDIUM   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_CLOSE    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FULL_P   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_ATM_THR  = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_CUTOFF   = 3'd6;

  localparam logic [RANGE_W-1:0] RST_FAR     = 16'd2000;
  localparam logic [RANGE_W-1:0] RST_MEDIUM  = 16'd800;
  localparam logic [RANGE_W-1:0] RST_CLOSE   = 16'd320;
  localparam logic [PRES_W-1:0]  RST_FULL_P  = 32'd10375680;
  localparam logic [PRES_W-1:0]  RST_ATM_THR = 32'd102;
  localparam logic [VOL_W-1:0]   RST_CUTOFF  = 16'd1311;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_UPDATE  = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    PT_INTERNAL = 3'd0,
    PT_RADIO    = 3'd1,
    PT_FAR      = 3'd2,
    PT_MEDIUM   = 3'd3,
    PT_CLOSE    = 3'd4,
    PT_WIND     = 3'd5,
    PT_GLOBAL   = 3'd6,
    PT_UNKNOWN  = 3'd7
  } ptype_t;

  typedef struct packed {
    logic               silence;
    logic [RANGE_W-1:0] far_dist;
    logic [RANGE_W-1:0] medium_dist;
    logic [RANGE_W-1:0] close_dist;
    logic [PRES_W-1:0]  full_p;
    logic [PRES_W-1:0]  atm_thr;
    logic [VOL_W-1:0]   cutoff;
  } cfg_t;

  typedef struct packed {
    action_t            action;
    logic [VOL_W-1:0]   vol;
    logic               loop_set;
    logic               pause_set;
    logic               do_dist;
    logic               do_press;
    logic               do_cut;
    logic [RANGE_W-1:0] range;
    logic [DIST_W-1:0]  cam_dist;
    logic [PRES_W-1:0]  pres;
  } work_t;

endpackage

FILE: hw/rtl/sva_front.sv
module sva_front (
  input  sva_pkg::cfg_t               cfg,
  input  logic                        sound_active,
  input  logic                        sound_finished,
  input  logic                        sound_enabled,
  input  logic [2:0]                  playback_type,
  input  logic [sva_pkg::VOL_W-1:0]   base_volume,
  input  logic                        loop_request,
  input  logic                        pause_request,
  input  logic                        in_cockpit_view,
  input  logic                        has_focus,
  input  logic [sva_pkg::DIST_W-1:0]  camera_distance,
  input  logic [sva_pkg::PRES_W-1:0]  static_pressure,
  output sva_pkg::work_t              work
);

  sva_pkg::ptype_t              ptype;
  sva_pkg::action_t             action;
  logic [sva_pkg::VOL_W-1:0]    vol_sat;
  logic [sva_pkg::VOL_W-1:0]    vol_sel;
  logic [sva_pkg::RANGE_W-1:0]  range;
  logic [sva_pkg::DIST_W-1:0]   cam_dist;
  logic                         is_dist;
  logic                         upd;
  logic                         vac_mute;
  logic                         dist_path;
  logic                         press_ok;

  assign ptype    = sva_pkg::ptype_t'(playback_type);
  assign vol_sat  = (base_volume > sva_pkg::VOL_FULL) ? sva_pkg::VOL_FULL : base_volume;
  assign cam_dist = (camera_distance == '0) ? sva_pkg::DIST_MIN : camera_distance;

  always_comb begin
    is_dist = 1'b0;
    range   = cfg.far_dist;
    unique case (ptype)
      sva_pkg::PT_FAR: begin
        is_dist = 1'b1;
        range   = cfg.far_dist;
      end
      sva_pkg::PT_MEDIUM: begin
        is_dist = 1'b1;
        range   = cfg.medium_dist;
      end
      sva_pkg::PT_CLOSE: begin
        is_dist = 1'b1;
        range   = cfg.close_dist;
      end
      default: begin
        is_dist = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (!sound_active) begin
      action = sva_pkg::ACT_NONE;
    end else if (sound_finished) begin
      action = sva_pkg::ACT_RELEASE;
    end else if (!sound_enabled) begin
      action = sva_pkg::ACT_STOP;
    end else if (ptype == sva_pkg::PT_UNKNOWN) begin
      action = sva_pkg::ACT_RELEASE;
    end else begin
      action = sva_pkg::ACT_UPDATE;
    end
  end

  assign upd       = (action == sva_pkg::ACT_UPDATE);
  assign vac_mute  = cfg.silence && !(static_pressure > cfg.atm_thr);
  assign dist_path = upd && is_dist && !in_cockpit_view;
  assign press_ok  = cfg.silence && (cfg.full_p != '0) && (static_pressure < cfg.full_p);

  always_comb begin
    case (ptype)
      sva_pkg::PT_INTERNAL: vol_sel = in_cockpit_view ? vol_sat : '0;
      sva_pkg::PT_RADIO:    vol_sel = has_focus ? vol_sat : '0;
      default:              vol_sel = (dist_path && vac_mute) ? '0 : vol_sat;
    endcase
  end

  always_comb begin
    work.action    = action;
    work.vol       = upd ? vol_sel : '0;
    work.loop_set  = upd && loop_request;
    work.pause_set = upd && pause_request;
    work.do_dist   = dist_path && !vac_mute && (cam_dist > {16'd0, range});
    work.do_press  = upd && press_ok &&
                     ((dist_path && !vac_mute) || (ptype == sva_pkg::PT_WIND));
    work.do_cut    = dist_path;
    work.range     = range;
    work.cam_dist  = cam_dist;
    work.pres      = static_pressure;
  end

endmodule

FILE: hw/rtl/sva_queue.sv
module sva_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sva_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output sva_pkg::work_t pop_data,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sva_pkg::work_t     entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/sva_div.sv
module sva_div #(
  parameter int NW = 48,
  parameter int DW = 64,
  parameter int QW = 16,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  localparam int EW = DW + QW;

  logic          vld_w [QW+1];
  logic [NW-1:0] rem_w [QW+1];
  logic [DW-1:0] den_w [QW+1];
  logic [QW-1:0] quo_w [QW+1];
  logic [PW-1:0] pay_w [QW+1];

  assign vld_w[0] = in_valid;
  assign rem_w[0] = in_num;
  assign den_w[0] = in_den;
  assign quo_w[0] = '0;
  assign pay_w[0] = in_pay;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;

    logic          vld_r;
    logic [NW-1:0] rem_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] quo_r;
    logic [PW-1:0] pay_r;
    logic [EW-1:0] sub;
    logic          ge;

    assign sub = EW'(den_w[k]) << SH;
    assign ge  = (EW'(rem_w[k]) >= sub);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= vld_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? (rem_w[k] - sub[NW-1:0]) : rem_w[k];
        den_r <= den_w[k];
        quo_r <= quo_w[k] | (QW'(ge) << SH);
        pay_r <= pay_w[k];
      end
    end

    assign vld_w[k+1] = vld_r;
    assign rem_w[k+1] = rem_r;
    assign den_w[k+1] = den_r;
    assign quo_w[k+1] = quo_r;
    assign pay_w[k+1] = pay_r;
  end

  assign out_valid = vld_w[QW];
  assign out_quo   = quo_w[QW];
  assign out_pay   = pay_w[QW];

endmodule

FILE: hw/rtl/sva_back.sv
module sva_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sva_pkg::cfg_t               cfg,
  input  logic                        q_empty,
  input  sva_pkg::work_t              q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_action,
  output logic [sva_pkg::VOL_W-1:0]   out_volume_out,
  output logic                        out_loop_out,
  output logic                        out_paused_out
);

  localparam int PW = $bits(sva_pkg::work_t);

  logic                          en;
  logic                          v1_r, v2_r, v4_r;
  sva_pkg::work_t                w1_r, w2_r, w4_r, w3, w5;
  sva_pkg::work_t                w4_nxt;
  logic [31:0]                   vm1_r;
  logic [63:0]                   dd1_r, dd2_r;
  logic [sva_pkg::NUM_W-1:0]     num2_r, pv4_r;
  logic                          v3, v5;
  logic [PW-1:0]                 pay3, pay5;
  logic [sva_pkg::QUO_W-1:0]     q3, q5;
  logic [sva_pkg::VOL_W-1:0]     vol_a, vol_b, vol_c;
  logic                          out_valid_r;
  logic [1:0]                    out_action_r;
  logic [sva_pkg::VOL_W-1:0]     out_vol_r;
  logic                          out_loop_r;
  logic                          out_pause_r;

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= !q_empty;
      v2_r <= v1_r;
      v4_r <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r   <= q_data;
      vm1_r  <= q_data.vol * q_data.range;
      dd1_r  <= q_data.cam_dist * q_data.cam_dist;
      w2_r   <= w1_r;
      num2_r <= vm1_r * w1_r.range;
      dd2_r  <= dd1_r;
    end
  end

  sva_div #(.NW(sva_pkg::NUM_W), .DW(64), .QW(sva_pkg::QUO_W), .PW(PW)) u_div_dist (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v2_r), .in_num(num2_r), .in_den(dd2_r), .in_pay(w2_r),
    .out_valid(v3), .out_quo(q3), .out_pay(pay3)
  );

  assign w3    = sva_pkg::work_t'(pay3);
  assign vol_a = w3.do_dist ? q3 : w3.vol;

  always_comb begin
    w4_nxt     = w3;
    w4_nxt.vol = vol_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w4_r  <= w4_nxt;
      pv4_r <= vol_a * w3.pres;
    end
  end

  sva_div #(.NW(sva_pkg::NUM_W), .DW(sva_pkg::PRES_W), .QW(sva_pkg::QUO_W), .PW(PW))
    u_div_press (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(v4_r), .in_num(pv4_r), .in_den(cfg.full_p), .in_pay(w4_r),
    .out_valid(v5), .out_quo(q5), .out_pay(pay5)
  );

  assign w5    = sva_pkg::work_t'(pay5);
  assign vol_b = w5.do_press ? q5 : w5.vol;
  assign vol_c = (w5.do_cut && (vol_b < cfg.cutoff)) ? '0 : vol_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_action_r <= w5.action;
      out_vol_r    <= vol_c;
      out_loop_r   <= w5.loop_set;
      out_pause_r  <= w5.pause_set;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_volume_out = out_vol_r;
  assign out_loop_out   = out_loop_r;
  assign out_paused_out = out_pause_r;

endmodule

FILE: hw/rtl/sound_volume_attenuator.sv
// Sound volume attenuator. Each item is one sound's update request and gives
// exactly one result: no action, release, stop, or an update with volume,
// loop and pause settings. The block takes one item per clock cycle while its
// queue is not full and keeps no state between items. Each item passes through
// the queue, the multiplier stages and the two pipelined 16-stage dividers
// (distance fade, then pressure fade) to an output register, and the whole
// pipeline holds while the output side stalls. A QUEUE_DEPTH-entry queue
// separates intake from the arithmetic pipeline, so the input keeps accepting
// up to QUEUE_DEPTH items while the output is held. The user must write
// configuration registers only while the block is idle; it is not enforced.
module sound_volume_attenuator #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_sound_active,
  input  logic        in_sound_finished,
  input  logic        in_sound_enabled,
  input  logic [2:0]  in_playback_type,
  input  logic [15:0] in_base_volume,
  input  logic        in_loop_request,
  input  logic        in_pause_request,
  input  logic        in_in_cockpit_view,
  input  logic        in_has_focus,
  input  logic [31:0] in_camera_distance,
  input  logic [31:0] in_static_pressure,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic [15:0] out_volume_out,
  output logic        out_loop_out,
  output logic        out_paused_out
);

  sva_pkg::cfg_t  cfg_r;
  sva_pkg::work_t front_work;
  sva_pkg::work_t q_data;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.silence     <= 1'b1;
      cfg_r.far_dist    <= sva_pkg::RST_FAR;
      cfg_r.medium_dist <= sva_pkg::RST_MEDIUM;
      cfg_r.close_dist  <= sva_pkg::RST_CLOSE;
      cfg_r.full_p      <= sva_pkg::RST_FULL_P;
      cfg_r.atm_thr     <= sva_pkg::RST_ATM_THR;
      cfg_r.cutoff      <= sva_pkg::RST_CUTOFF;
    end else if (cfg_we) begin
      case (cfg_index)
        sva_pkg::CFG_SILENCE: cfg_r.silence     <= cfg_data[0];
        sva_pkg::CFG_FAR:     cfg_r.far_dist    <= cfg_data[15:0];
        sva_pkg::CFG_MEDIUM:  cfg_r.medium_dist <= cfg_data[15:0];
        sva_pkg::CFG_CLOSE:   cfg_r.close_dist  <= cfg_data[15:0];
        sva_pkg::CFG_FULL_P:  cfg_r.full_p      <= cfg_data;
        sva_pkg::CFG_ATM_THR: cfg_r.atm_thr     <= cfg_data;
        sva_pkg::CFG_CUTOFF:  cfg_r.cutoff      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  sva_front u_front (
    .cfg(cfg_r),
    .sound_active(in_sound_active),
    .sound_finished(in_sound_finished),
    .sound_enabled(in_sound_enabled),
    .playback_type(in_playback_type),
    .base_volume(in_base_volume),
    .loop_request(in_loop_request),
    .pause_request(in_pause_request),
    .in_cockpit_view(in_in_cockpit_view),
    .has_focus(in_has_focus),
    .camera_distance(in_camera_distance),
    .static_pressure(in_static_pressure),
    .work(front_work)
  );

  assign in_ready = !q_full;

  sva_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(in_valid), .push_data(front_work), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty)
  );

  sva_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_action(out_action), .out_volume_out(out_volume_out),
    .out_loop_out(out_loop_out), .out_paused_out(out_paused_out)
  );

endmodule

FILE: hw/rtl/sva_checker.sv
module sva_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_action,
  input logic [15:0] out_volume_out,
  input logic        out_loop_out,
  input logic        out_paused_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
    $stable(out_volume_out) && $stable(out_loop_out) && $stable(out_paused_out))
    else $error("result changed while stalled");

  a_non_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != sva_pkg::ACT_UPDATE) |->
    (out_volume_out == '0) && !out_loop_out && !out_paused_out)
    else $error("non-update result carries settings");

  a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_volume_out <= sva_pkg::VOL_FULL)
    else $error("volume above full scale");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sound_volume_attenuator sva_checker u_sva_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_action(out_action), .out_volume_out(out_volume_out),
  .out_loop_out(out_loop_out), .out_paused_out(out_paused_out)
);

FILE: tb/sv/sound_volume_attenuator_test.sv
`timescale 1ns / 1ps

module sound_volume_attenuator_test;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

  typedef struct packed {
    logic             active;
    logic             finished;
    logic             enabled;
    sva_pkg::ptype_t  ptype;
    logic [15:0]      vol;
    logic             loop_req;
    logic             pause_req;
    logic             cockpit;
    logic             focus;
    logic [31:0]      cam_dist;
    logic [31:0]      pres;
  } request_t;

  typedef struct packed {
    sva_pkg::action_t action;
    logic [15:0]      vol;
    logic             loop_set;
    logic             pause_set;
  } update_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  request_t    req;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_action;
  logic [15:0] out_volume_out;
  logic        out_loop_out;
  logic        out_paused_out;

  logic        silence;
  logic [15:0] far_dist;
  logic [15:0] medium_dist;
  logic [15:0] close_dist;
  logic [31:0] full_p;
  logic [31:0] atm_thr;
  logic [15:0] cutoff;

  update_t     pending_updates[$];
  int          error_count;
  int          idle_cycles;
  bit          calm;

  sound_volume_attenuator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sound_active   (req.active),
    .in_sound_finished (req.finished),
    .in_sound_enabled  (req.enabled),
    .in_playback_type  (req.ptype),
    .in_base_volume    (req.vol),
    .in_loop_request   (req.loop_req),
    .in_pause_request  (req.pause_req),
    .in_in_cockpit_view(req.cockpit),
    .in_has_focus      (req.focus),
    .in_camera_distance(req.cam_dist),
    .in_static_pressure(req.pres),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_volume_out    (out_volume_out),
    .out_loop_out      (out_loop_out),
    .out_paused_out    (out_paused_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] pressure_faded(logic [31:0] v, logic [31:0] p);
    logic [63:0] scaled;
    if (!silence || full_p == 0 || p >= full_p) begin
      return v;
    end
    scaled = (64'(v) * 64'(p)) / 64'(full_p);
    return (scaled < 64'(v)) ? scaled[31:0] : v;
  endfunction

  function automatic logic [31:0] distance_faded(logic [31:0] v, logic [15:0] maxd,
                                                 request_t r);
    logic [63:0] d;
    logic [63:0] q;
    if (r.cockpit) begin
      return v;
    end
    if (!(r.pres > atm_thr) && silence) begin
      return 0;
    end
    d = (r.cam_dist == 0) ? 64'd2 : 64'(r.cam_dist);
    if (d > 64'(maxd)) begin
      q = (64'(v) * 64'(maxd) * 64'(maxd)) / (d * d);
      if (q < 64'(v)) begin
        v = q[31:0];
      end
    end
    v = pressure_faded(v, r.pres);
    if (v < 32'(cutoff)) begin
      v = 0;
    end
    return v;
  endfunction

  function automatic update_t volume_update(request_t r);
    update_t     u;
    logic [31:0] v;
    u = '0;
    u.action = sva_pkg::ACT_NONE;
    if (!r.active) begin
      return u;
    end
    if (r.finished) begin
      u.action = sva_pkg::ACT_RELEASE;
      return u;
    end
    if (!r.enabled) begin
      u.action = sva_pkg::ACT_STOP;
      return u;
    end
    v = (r.vol > sva_pkg::VOL_FULL) ? 32'(sva_pkg::VOL_FULL) : 32'(r.vol);
    case (r.ptype)
      sva_pkg::PT_INTERNAL: if (!r.cockpit) v = 0;
      sva_pkg::PT_RADIO: if (!r.focus) v = 0;
      sva_pkg::PT_FAR: v = distance_faded(v, far_dist, r);
      sva_pkg::PT_MEDIUM: v = distance_faded(v, medium_dist, r);
      sva_pkg::PT_CLOSE: v = distance_faded(v, close_dist, r);
      sva_pkg::PT_WIND: v = pressure_faded(v, r.pres);
      sva_pkg::PT_GLOBAL: ;
      default: begin
        u.action = sva_pkg::ACT_RELEASE;
        return u;
      end
    endcase
    u.action = sva_pkg::ACT_UPDATE;
    u.vol = v[15:0];
    u.loop_set = r.loop_req;
    u.pause_set = r.pause_req;
    return u;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_val);
    error_count++;
  endtask

  always @(posedge clk) begin
    update_t u;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_updates.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_action), 32'd0);
        end else begin
          u = pending_updates.pop_front();
          if (out_action != u.action) begin
            report_mismatch("action", 32'(out_action), 32'(u.action));
          end
          if (out_volume_out != u.vol) begin
            report_mismatch("volume", 32'(out_volume_out), 32'(u.vol));
          end
          if (out_loop_out != u.loop_set) begin
            report_mismatch("loop", 32'(out_loop_out), 32'(u.loop_set));
          end
          if (out_paused_out != u.pause_set) begin
            report_mismatch("pause", 32'(out_paused_out), 32'(u.pause_set));
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_request(request_t r);
    if (!calm) begin
      while ($urandom_range(99) < 12) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    req <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pending_updates = {pending_updates, volume_update(r)};
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [31:0] data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (index)
      sva_pkg::CFG_SILENCE: silence = data[0];
      sva_pkg::CFG_FAR: far_dist = data[15:0];
      sva_pkg::CFG_MEDIUM: medium_dist = data[15:0];
      sva_pkg::CFG_CLOSE: close_dist = data[15:0];
      sva_pkg::CFG_FULL_P: full_p = data;
      sva_pkg::CFG_ATM_THR: atm_thr = data;
      sva_pkg::CFG_CUTOFF: cutoff = data[15:0];
      default: ;
    endcase
  endtask

  function automatic request_t random_request();
    request_t r;
    r.active = ($urandom_range(19) != 0);
    r.finished = ($urandom_range(19) == 0);
    r.enabled = ($urandom_range(19) != 0);
    r.ptype = sva_pkg::ptype_t'($urandom_range(7));
    case ($urandom_range(3))
      0: r.vol = 16'($urandom());
      1: r.vol = sva_pkg::VOL_FULL;
      default: r.vol = 16'($urandom_range(32768));
    endcase
    r.loop_req = 1'($urandom());
    r.pause_req = 1'($urandom());
    r.cockpit = ($urandom_range(3) == 0);
    r.focus = 1'($urandom());
    case ($urandom_range(4))
      0: r.cam_dist = $urandom();
      1: r.cam_dist = $urandom_range(3);
      default: r.cam_dist = $urandom_range(20000);
    endcase
    case ($urandom_range(4))
      0: r.pres = $urandom();
      1: r.pres = $urandom_range(200);
      default: r.pres = $urandom_range(12000000);
    endcase
    return r;
  endfunction

  function automatic request_t base_request(sva_pkg::ptype_t t);
    request_t r;
    r = '0;
    r.active = 1'b1;
    r.enabled = 1'b1;
    r.ptype = t;
    r.vol = 16'd20000;
    r.loop_req = 1'b1;
    r.cam_dist = 32'd5000;
    r.pres = 32'd5000000;
    return r;
  endfunction

  task automatic test_directed();
    request_t r;
    r = base_request(sva_pkg::PT_GLOBAL);
    r.active = 1'b0;
    send_request(r);
    r = base_request(sva_pkg::PT_GLOBAL);
    r.finished = 1'b1;
    send_request(r);
    r = base_request(sva_pkg::PT_GLOBAL);
    r.enabled = 1'b0;
    send_request(r);
    for (int t = 0; t < 8; t++) begin
      r = base_request(sva_pkg::ptype_t'(t));
      r.pause_req = t[0];
      send_request(r);
      r.cockpit = 1'b1;
      r.focus = 1'b1;
      send_request(r);
    end
    r = base_request(sva_pkg::PT_CLOSE);
    r.cam_dist = 0;
    r.vol = 16'hFFFF;
    send_request(r);
    r = base_request(sva_pkg::PT_FAR);
    r.cam_dist = 32'hFFFFFFFF;
    r.pres = 32'hFFFFFFFF;
    send_request(r);
    r = base_request(sva_pkg::PT_WIND);
    r.pres = 32'hFFFFFFFF;
    send_request(r);
    r = base_request(sva_pkg::PT_MEDIUM);
    r.pres = 0;
    send_request(r);
    r = base_request(sva_pkg::PT_MEDIUM);
    r.pres = 32'd103;
    send_request(r);
    wait_for_drain();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 2);
      send_request(random_request());
    end
    calm = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_extreme_settings();
    request_t r;
    write_register(sva_pkg::CFG_SILENCE, 32'd0);
    write_register(sva_pkg::CFG_FAR, 32'h0000FFFF);
    write_register(sva_pkg::CFG_MEDIUM, 32'd1);
    write_register(sva_pkg::CFG_CLOSE, 32'd0);
    write_register(sva_pkg::CFG_FULL_P, 32'hFFFFFFFF);
    write_register(sva_pkg::CFG_ATM_THR, 32'd0);
    write_register(sva_pkg::CFG_CUTOFF, 32'd0);
    write_register(CFG_UNUSED_INDEX, 32'hFFFFFFFF);
    for (int t = 2; t < 6; t++) begin
      r = base_request(sva_pkg::ptype_t'(t));
      send_request(r);
    end
    test_random(200);
    write_register(sva_pkg::CFG_SILENCE, 32'd1);
    write_register(sva_pkg::CFG_FULL_P, 32'd0);
    write_register(sva_pkg::CFG_ATM_THR, 32'hFFFFFFFF);
    write_register(sva_pkg::CFG_CUTOFF, 32'd32768);
    write_register(sva_pkg::CFG_MEDIUM, 32'h0000FFFF);
    write_register(sva_pkg::CFG_FAR, 32'd1);
    write_register(sva_pkg::CFG_CLOSE, 32'd3000);
    test_random(200);
    write_register(sva_pkg::CFG_FULL_P, 32'd1);
    write_register(sva_pkg::CFG_ATM_THR, 32'd1000);
    write_register(sva_pkg::CFG_CUTOFF, 32'd500);
    test_random(150);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req = '0;
    calm = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    silence = 1'b1;
    far_dist = sva_pkg::RST_FAR;
    medium_dist = sva_pkg::RST_MEDIUM;
    close_dist = sva_pkg::RST_CLOSE;
    full_p = sva_pkg::RST_FULL_P;
    atm_thr = sva_pkg::RST_ATM_THR;
    cutoff = sva_pkg::RST_CUTOFF;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(500);
    test_extreme_settings();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sva_pkg.sv
hw/rtl/sva_front.sv
hw/rtl/sva_queue.sv
hw/rtl/sva_div.sv
hw/rtl/sva_back.sv
hw/rtl/sound_volume_attenuator.sv
hw/rtl/sva_checker.sv
tb/sv/sound_volume_attenuator_test.sv
